/* rtl/core/asbr_pkg.sv */
package asbr_pkg;

    localparam int CHAR_W         = 8;
    localparam int POS_W          = 8;
    localparam int WORD_W         = 32;
    localparam int CNT_W          = 5;
    localparam int SYM_W          = 4;
    localparam int WB_W           = 6;
    localparam int REM_W          = 4;
    localparam int ALPHABET_DEPTH = 256;
    localparam int MAX_WORD_BITS  = 32;
    localparam int MAX_SYM_BITS   = 8;

    localparam logic [SYM_W-1:0] SYM_BITS_RST  = SYM_W'(6);
    localparam logic [WB_W-1:0]  WORD_BITS_RST = WB_W'(8);

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_DECODE = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic {
        REG_SYMBOL_BITS = 1'b0,
        REG_WORD_BITS   = 1'b1
    } t_reg;

    // effective (clamped) configuration
    typedef struct packed {
        logic [SYM_W-1:0] sym_bits;
        logic [WB_W-1:0]  word_bits;
    } t_cfg;

    typedef struct packed {
        logic              set_valid;
        logic              wr_idx;
        logic              clr;
        logic [CHAR_W-1:0] addr;
        logic [POS_W-1:0]  data;
    } t_map_wr;

endpackage

/* rtl/core/asbr_cfg.sv */
module asbr_cfg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_psel,
    input  logic                   i_penable,
    input  logic                   i_pwrite,
    input  logic [2:0]             i_paddr,
    input  logic [31:0]            i_pwdata,
    output logic [31:0]            o_prdata,
    output asbr_pkg::t_cfg         o_cfg
);

    logic [asbr_pkg::SYM_W-1:0] r_sym_bits;
    logic [asbr_pkg::WB_W-1:0]  r_word_bits;
    asbr_pkg::t_reg             reg_sel;
    logic                       wr;

    assign reg_sel = asbr_pkg::t_reg'(i_paddr[2]);
    assign wr      = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_bits  <= asbr_pkg::SYM_BITS_RST;
            r_word_bits <= asbr_pkg::WORD_BITS_RST;
        end else if (wr) begin
            unique case (reg_sel)
                asbr_pkg::REG_SYMBOL_BITS: r_sym_bits  <= i_pwdata[asbr_pkg::SYM_W-1:0];
                asbr_pkg::REG_WORD_BITS:   r_word_bits <= i_pwdata[asbr_pkg::WB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            asbr_pkg::REG_SYMBOL_BITS: o_prdata = 32'(r_sym_bits);
            asbr_pkg::REG_WORD_BITS:   o_prdata = 32'(r_word_bits);
            default:                   o_prdata = '0;
        endcase
    end

    always_comb begin
        if (r_sym_bits == '0) begin
            o_cfg.sym_bits = asbr_pkg::SYM_W'(1);
        end else if (r_sym_bits > asbr_pkg::SYM_W'(asbr_pkg::MAX_SYM_BITS)) begin
            o_cfg.sym_bits = asbr_pkg::SYM_W'(asbr_pkg::MAX_SYM_BITS);
        end else begin
            o_cfg.sym_bits = r_sym_bits;
        end
        if (r_word_bits == '0) begin
            o_cfg.word_bits = asbr_pkg::WB_W'(1);
        end else if (r_word_bits > asbr_pkg::WB_W'(asbr_pkg::MAX_WORD_BITS)) begin
            o_cfg.word_bits = asbr_pkg::WB_W'(asbr_pkg::MAX_WORD_BITS);
        end else begin
            o_cfg.word_bits = r_word_bits;
        end
    end

endmodule

/* rtl/core/asbr_symbol_map.sv */
module asbr_symbol_map (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rd_en,
    input  logic [asbr_pkg::CHAR_W-1:0]     i_rd_addr,
    input  logic [asbr_pkg::CHAR_W-1:0]     i_chk_addr,
    input  asbr_pkg::t_map_wr               i_wr,
    output logic [asbr_pkg::POS_W-1:0]      o_q,
    output logic                            o_valid
);

    logic [asbr_pkg::POS_W-1:0] mem [asbr_pkg::ALPHABET_DEPTH];
    logic [asbr_pkg::POS_W-1:0] r_rdata;
    logic [asbr_pkg::POS_W-1:0] r_fwd_data;
    logic                       r_fwd_hit;
    logic [asbr_pkg::ALPHABET_DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_idx) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rdata    <= mem[i_rd_addr];
            r_fwd_data <= i_wr.data;
        end
    end

    // write to the same entry in the read cycle bypasses the array
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr.wr_idx && (i_wr.addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clr) begin
            r_valid <= '0;
        end else if (i_wr.set_valid) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    assign o_q     = r_fwd_hit ? r_fwd_data : r_rdata;
    assign o_valid = r_valid[i_chk_addr];

endmodule

/* rtl/core/asbr_packer.sv */
module asbr_packer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  asbr_pkg::t_cfg                  i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  asbr_pkg::t_cmd                  i_cmd,
    input  logic [asbr_pkg::CHAR_W-1:0]     i_char,
    input  logic [asbr_pkg::POS_W-1:0]      i_pos,
    output logic                            o_rd_en,
    output logic [asbr_pkg::CHAR_W-1:0]     o_rd_addr,
    output logic [asbr_pkg::CHAR_W-1:0]     o_chk_addr,
    input  logic [asbr_pkg::POS_W-1:0]      i_map_q,
    input  logic                            i_map_valid,
    output asbr_pkg::t_map_wr               o_map_wr,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [asbr_pkg::WORD_W-1:0]     o_word,
    output logic                            o_last,
    output logic                            o_partial
);

    function automatic logic [asbr_pkg::POS_W-1:0] low_mask(input logic [asbr_pkg::REM_W-1:0] k);
        logic [asbr_pkg::POS_W:0] m;
        m = ((asbr_pkg::POS_W+1)'(1) << k) - (asbr_pkg::POS_W+1)'(1);
        return m[asbr_pkg::POS_W-1:0];
    endfunction

    logic                           r_s1_valid;
    asbr_pkg::t_cmd                 r_cmd;
    logic [asbr_pkg::CHAR_W-1:0]    r_char;
    logic [asbr_pkg::POS_W-1:0]     r_pos;
    logic [asbr_pkg::REM_W-1:0]     r_rem;
    logic [asbr_pkg::WORD_W-1:0]    r_acc;
    logic [asbr_pkg::CNT_W-1:0]     r_cnt;
    logic                           r_out_valid;
    logic [asbr_pkg::WORD_W-1:0]    r_word;
    logic                           r_last;
    logic                           r_partial;

    logic [asbr_pkg::POS_W-1:0]     idx;
    logic [asbr_pkg::WB_W-1:0]      cnt_w;
    logic [asbr_pkg::WB_W-1:0]      rem_w;
    logic [asbr_pkg::WB_W-1:0]      wb;
    logic                           over;
    logic                           dec_emit;
    logic [asbr_pkg::REM_W-1:0]     take;
    logic [asbr_pkg::REM_W-1:0]     rest;
    logic [asbr_pkg::POS_W-1:0]     chunk;
    logic [asbr_pkg::WORD_W-1:0]    shifted;
    logic [asbr_pkg::POS_W-1:0]     tail;
    logic                           more;
    logic                           emit;
    logic                           out_free;
    logic                           step;
    logic                           done;
    logic                           accept;
    logic                           pos_ok;

    always_comb begin
        idx      = i_map_valid ? i_map_q : '0;
        cnt_w    = asbr_pkg::WB_W'(r_cnt);
        rem_w    = asbr_pkg::WB_W'(r_rem);
        wb       = i_cfg.word_bits;
        over     = cnt_w >= wb;
        dec_emit = over || ((cnt_w + rem_w) >= wb);
        if (over) begin
            take = asbr_pkg::REM_W'(1);
        end else if (dec_emit) begin
            take = asbr_pkg::REM_W'(wb - cnt_w);
        end else begin
            take = r_rem;
        end
        rest     = r_rem - take;
        chunk    = (idx >> rest) & low_mask(take);
        shifted  = (r_acc << take) | asbr_pkg::WORD_W'(chunk);
        tail     = idx & low_mask(rest);
        more     = dec_emit && (asbr_pkg::WB_W'(rest) >= wb);
        emit     = r_s1_valid
                 && (((r_cmd == asbr_pkg::CMD_DECODE) && dec_emit)
                 ||  ((r_cmd == asbr_pkg::CMD_FLUSH) && (r_cnt != '0)));
        out_free = !r_out_valid || i_out_ready;
        step     = r_s1_valid && (!emit || out_free);
        done     = step && !((r_cmd == asbr_pkg::CMD_DECODE) && more);
        pos_ok   = (r_pos >> i_cfg.sym_bits) == '0;
    end

    assign o_in_ready = !r_s1_valid || done;
    assign accept     = i_in_valid && o_in_ready;
    assign o_rd_en    = accept;
    assign o_rd_addr  = i_char;
    assign o_chk_addr = r_char;

    always_comb begin
        o_map_wr.set_valid = step && (r_cmd == asbr_pkg::CMD_LOAD) && pos_ok;
        o_map_wr.wr_idx    = o_map_wr.set_valid && (!i_map_valid || (r_pos < i_map_q));
        o_map_wr.clr       = step && (r_cmd == asbr_pkg::CMD_CLEAR);
        o_map_wr.addr      = r_char;
        o_map_wr.data      = r_pos;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_cmd;
            r_char <= i_char;
            r_pos  <= i_pos;
        end
        if (emit && step) begin
            if (r_cmd == asbr_pkg::CMD_DECODE) begin
                r_word    <= shifted;
                r_last    <= !more;
                r_partial <= 1'b0;
            end else begin
                r_word    <= r_acc << 1;
                r_last    <= 1'b1;
                r_partial <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_rem       <= '0;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_rem      <= i_cfg.sym_bits;
            end else if (done) begin
                r_s1_valid <= 1'b0;
            end

            if (step) begin
                case (r_cmd)
                    asbr_pkg::CMD_DECODE: begin
                        if (!dec_emit) begin
                            r_acc <= shifted;
                            r_cnt <= asbr_pkg::CNT_W'(cnt_w + rem_w);
                        end else if (more) begin
                            r_acc <= '0;
                            r_cnt <= '0;
                            r_rem <= rest;
                        end else begin
                            r_acc <= asbr_pkg::WORD_W'(tail);
                            r_cnt <= asbr_pkg::CNT_W'(rest);
                        end
                    end
                    asbr_pkg::CMD_FLUSH: begin
                        r_acc <= '0;
                        r_cnt <= '0;
                    end
                    default: ;
                endcase
            end

            if (emit && step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word      = r_word;
    assign o_last      = r_last;
    assign o_partial   = r_partial;

endmodule

/* rtl/core/alphabet_symbol_bit_repacker.sv */
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: char_code, alpha_position; tuser: cmd
// m_*       out  m_tvalid/m_tready   tdata: word; tlast: last_of_run; tuser: is_partial
// apb       in   psel/penable/pready reg 0 symbol_bits @0x0, reg 1 word_bits @0x4
//
// One item per cycle unless the output register stalls; a decode that fills k
// words holds the input until all pass the output register, one word per cycle
// while unstalled. The symbol map is read at transfer, used from the next cycle.
// Synchronous active-low reset; the valid marks clear at once, no sweep.
// A full output register stalls only items that produce a word.
module alphabet_symbol_bit_repacker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_code, [15:8] alpha_position
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] word
    output logic        m_tlast,
    output logic        m_tuser,   // [0] is_partial
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    asbr_pkg::t_cfg                   cfg;
    asbr_pkg::t_map_wr                map_wr;
    logic                             rd_en;
    logic [asbr_pkg::CHAR_W-1:0]      rd_addr;
    logic [asbr_pkg::CHAR_W-1:0]      chk_addr;
    logic [asbr_pkg::POS_W-1:0]       map_q;
    logic                             map_valid;

    assign pready = 1'b1;

    asbr_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg)
    );

    asbr_symbol_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .i_chk_addr (chk_addr),
        .i_wr       (map_wr),
        .o_q        (map_q),
        .o_valid    (map_valid)
    );

    asbr_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .i_cmd       (asbr_pkg::t_cmd'(s_tuser)),
        .i_char      (s_tdata[7:0]),
        .i_pos       (s_tdata[15:8]),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_chk_addr  (chk_addr),
        .i_map_q     (map_q),
        .i_map_valid (map_valid),
        .o_map_wr    (map_wr),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .o_word      (m_tdata),
        .o_last      (m_tlast),
        .o_partial   (m_tuser)
    );

endmodule

/* tb/alphabet_symbol_bit_repacker_check.sv */
module alphabet_symbol_bit_repacker_check
    import asbr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] char_code, [15:8] alpha_position
    input  logic [1:0]  i_s_tuser,   // [1:0] cmd
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // [31:0] word
    input  logic        i_m_tlast,
    input  logic        i_m_tuser,   // [0] is_partial
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_words_pending
);

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              partial;
    } repacked_word_t;

    repacked_word_t     pending_words[$];
    logic [POS_W-1:0]   alpha_pos_of[ALPHABET_DEPTH];
    bit                 alpha_known[ALPHABET_DEPTH];
    logic [63:0]        pack_acc;
    int                 pack_cnt;
    logic [SYM_W-1:0]   cfg_sym_bits;
    logic [WB_W-1:0]    cfg_word_bits;
    int                 fail_count;

    initial begin
        fail_count      = 0;
        o_fail_count    = 0;
        o_words_pending = 0;
        foreach (alpha_pos_of[c]) alpha_pos_of[c] = '0;
    end

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic push_word(input logic [WORD_W-1:0] w, input logic partial);
        repacked_word_t e;
        e.word    = w;
        e.last    = 1'b0;
        e.partial = partial;
        pending_words.push_back(e);
    endtask

    task automatic repack_item(input t_cmd cmd, input logic [CHAR_W-1:0] ch,
                               input logic [POS_W-1:0] pos);
        int          sb;
        int          wb;
        int          span;
        int          before_n;
        logic [7:0]  idx;
        logic [63:0] shifted;
        sb       = (cfg_sym_bits == 0) ? 1 : (cfg_sym_bits > MAX_SYM_BITS) ? MAX_SYM_BITS
                                                                          : int'(cfg_sym_bits);
        wb       = (cfg_word_bits == 0) ? 1 : (cfg_word_bits > MAX_WORD_BITS) ? MAX_WORD_BITS
                                                                            : int'(cfg_word_bits);
        span     = 1 << sb;
        before_n = pending_words.size();
        case (cmd)
            CMD_LOAD: begin
                if (int'(pos) < span) begin
                    if (!alpha_known[ch] || pos < alpha_pos_of[ch])
                        alpha_pos_of[ch] = pos;
                    alpha_known[ch] = 1'b1;
                end
            end
            CMD_DECODE: begin
                idx = alpha_known[ch] ? alpha_pos_of[ch] : 8'd0;
                for (int k = sb; k > 0; k--) begin
                    pack_acc = {pack_acc[62:0], idx[k-1]};
                    pack_cnt++;
                    if (pack_cnt >= wb) begin
                        push_word(pack_acc[31:0], 1'b0);
                        pack_acc = '0;
                        pack_cnt = 0;
                    end
                end
            end
            CMD_FLUSH: begin
                if (pack_cnt != 0) begin
                    shifted = pack_acc << 1;
                    push_word(shifted[31:0], 1'b1);
                end
                pack_acc = '0;
                pack_cnt = 0;
            end
            default: begin
                foreach (alpha_known[c]) alpha_known[c] = 1'b0;
            end
        endcase
        if (pending_words.size() > before_n)
            pending_words[pending_words.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        repacked_word_t e;
        if (!i_rst_n) begin
            pending_words.delete();
            foreach (alpha_known[c]) alpha_known[c] = 1'b0;
            pack_acc      = '0;
            pack_cnt      = 0;
            cfg_sym_bits  = SYM_BITS_RST;
            cfg_word_bits = WORD_BITS_RST;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg'(i_paddr[2]))
                    REG_SYMBOL_BITS: cfg_sym_bits  = i_pwdata[SYM_W-1:0];
                    REG_WORD_BITS:   cfg_word_bits = i_pwdata[WB_W-1:0];
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_words.size() == 0) begin
                    report($sformatf("unexpected word %h", i_m_tdata));
                end else begin
                    e = pending_words.pop_front();
                    if (i_m_tdata !== e.word)
                        report($sformatf("word got %h want %h", i_m_tdata, e.word));
                    if (i_m_tlast !== e.last)
                        report($sformatf("last got %b want %b (word %h)",
                                         i_m_tlast, e.last, e.word));
                    if (i_m_tuser !== e.partial)
                        report($sformatf("partial got %b want %b (word %h)",
                                         i_m_tuser, e.partial, e.word));
                end
            end
            if (i_s_tvalid && i_s_tready)
                repack_item(t_cmd'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[15:8]);
        end
        o_words_pending <= pending_words.size();
        o_fail_count    <= fail_count;
    end

endmodule

/* tb/alphabet_symbol_bit_repacker_tb.sv */
module alphabet_symbol_bit_repacker_tb;
    import asbr_pkg::*;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // [7:0] char_code, [15:8] alpha_position
    logic [1:0]  s_tuser  = '0;     // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] word
    logic        m_tlast;
    logic        m_tuser;           // [0] is_partial
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int words_pending;
    bit idling_on = 1'b1;
    int stall_left = 0;

    alphabet_symbol_bit_repacker dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    alphabet_symbol_bit_repacker_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tuser       (s_tuser),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tlast       (m_tlast),
        .i_m_tuser       (m_tuser),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // output stalls: random bursts with m_tready low
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input t_cmd cmd, input logic [7:0] ch, input logic [7:0] pos);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, ch};
        s_tuser  <= cmd;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic write_reg(input t_reg r, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop input, wait out all expected words plus the no-result latency
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] loaded_chars[8];
        logic [3:0] sym_cfg;
        logic [5:0] wb_cfg;
        int         esb;
        int         r;
        logic [7:0] ch;
        logic [7:0] pos;

        foreach (loaded_chars[k]) loaded_chars[k] = 8'($urandom_range(0, 255));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: 6-bit symbols, 8-bit words
        send_item(CMD_DECODE, 8'h41, 8'h00);     // unknown char
        send_item(CMD_LOAD,   8'h41, 8'd5);
        send_item(CMD_LOAD,   8'h41, 8'd3);      // lower position wins
        send_item(CMD_LOAD,   8'h41, 8'd9);
        send_item(CMD_LOAD,   8'hFF, 8'd63);
        send_item(CMD_LOAD,   8'h00, 8'd64);     // beyond alphabet
        send_item(CMD_LOAD,   8'h7F, 8'd255);
        send_item(CMD_DECODE, 8'h41, 8'h00);
        send_item(CMD_DECODE, 8'hFF, 8'hFF);
        send_item(CMD_DECODE, 8'h00, 8'h00);
        send_item(CMD_FLUSH,  8'h00, 8'h00);
        send_item(CMD_FLUSH,  8'hFF, 8'hFF);     // nothing to flush
        send_item(CMD_CLEAR,  8'h00, 8'h00);
        send_item(CMD_DECODE, 8'h41, 8'h00);
        send_item(CMD_FLUSH,  8'h00, 8'h00);
        drain();

        write_reg(REG_SYMBOL_BITS, 32'd8);
        write_reg(REG_WORD_BITS,   32'd1);
        send_item(CMD_LOAD,   8'hAA, 8'hFF);
        send_item(CMD_LOAD,   8'h55, 8'h80);
        send_item(CMD_DECODE, 8'hAA, 8'h00);
        send_item(CMD_DECODE, 8'h55, 8'h00);
        drain();

        // zero widths act as one
        write_reg(REG_SYMBOL_BITS, 32'd0);
        write_reg(REG_WORD_BITS,   32'd0);
        send_item(CMD_LOAD,   8'h12, 8'd1);
        send_item(CMD_DECODE, 8'h12, 8'd0);
        send_item(CMD_DECODE, 8'hAA, 8'd0);      // wide stored position, low bit only
        drain();

        // oversized widths clamp to 8 and 32
        write_reg(REG_SYMBOL_BITS, 32'hFFFF_FFFF);
        write_reg(REG_WORD_BITS,   32'hFFFF_FFFF);
        send_item(CMD_DECODE, 8'hAA, 8'd0);
        send_item(CMD_DECODE, 8'h55, 8'd0);
        send_item(CMD_DECODE, 8'hAA, 8'd0);
        send_item(CMD_DECODE, 8'h55, 8'd0);
        send_item(CMD_DECODE, 8'hAA, 8'd0);
        drain();

        // word width lowered with 8 bits held
        write_reg(REG_SYMBOL_BITS, 32'd3);
        write_reg(REG_WORD_BITS,   32'd5);
        send_item(CMD_DECODE, 8'hAA, 8'd0);
        send_item(CMD_DECODE, 8'h55, 8'd0);
        send_item(CMD_FLUSH,  8'h00, 8'd0);

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            idling_on = (phase != 2 && phase != 5);
            sym_cfg = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15) * $urandom_range(0, 1))
                                                  : 4'($urandom_range(1, 8));
            wb_cfg  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 1) ? 0 : $urandom_range(33, 63))
                                                  : 6'($urandom_range(1, 32));
            write_reg(REG_SYMBOL_BITS, {28'($urandom), sym_cfg});
            write_reg(REG_WORD_BITS,   {26'($urandom), wb_cfg});
            esb = (sym_cfg == 0) ? 1 : (sym_cfg > 8) ? 8 : int'(sym_cfg);
            for (int n = 0; n < 20; n++) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    ch  = 8'($urandom_range(0, 255));
                    pos = (r < 21) ? 8'($urandom_range(0, (1 << esb) - 1)) : 8'($urandom_range(0, 255));
                    loaded_chars[$urandom_range(0, 7)] = ch;
                    send_item(CMD_LOAD, ch, pos);
                end else if (r < 85) begin
                    ch = $urandom_range(0, 2) ? loaded_chars[$urandom_range(0, 7)]
                                              : 8'($urandom_range(0, 255));
                    send_item(CMD_DECODE, ch, 8'($urandom_range(0, 255)));
                end else if (r < 96) begin
                    send_item(CMD_FLUSH, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end else begin
                    send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                end
            end
        end
        drain();

        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
